[rtl/mgpds_pkg.sv]
// ----------------------------------------------------------------------------
// mgpds_pkg
// Shared types and constants of the GOP picture duration scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mgpds_pkg;

   // Start codes, as seen in the 32-bit byte window.
   localparam logic [31:0] GOP_CODE = 32'h0000_01B8;
   localparam logic [31:0] PIC_CODE = 32'h0000_0100;

   // Field widths of the ports and the internal time arithmetic.
   localparam int RATE_W  = 7;
   localparam int START_W = 23;
   localparam int DUR_W   = 25;
   localparam int GOPPIC_W = 16;
   localparam int SECS_W  = 17;
   localparam int PROD_W  = SECS_W + RATE_W;
   localparam int PP_W    = 6;

   // Configuration register indexes.
   localparam logic CSR_FRAME_RATE = 1'b0;
   localparam logic CSR_FIRST_TIME = 1'b1;
   localparam logic [RATE_W-1:0]  FRAME_RATE_RESET = 7'd25;
   localparam logic [START_W-1:0] FIRST_TIME_RESET = 23'd0;

   // Time code constants.
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;

   // Duration limits.
   localparam int DUR_MAX = 16777215;
   localparam int DUR_MIN = -16777216;

   // Controller states.
   typedef enum logic [1:0] {
      ST_SCAN,
      ST_DECODE,
      ST_MULT,
      ST_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic scan_en;
      logic decode_en;
      logic mult_en;
      logic load_en;
   } dp_cmd_type;

endpackage

`default_nettype wire

[rtl/mpeg2_gop_picture_duration_scanner.sv]
// ----------------------------------------------------------------------------
// mpeg2_gop_picture_duration_scanner
// Scans an MPEG-2 video stream and reports its duration in frames.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle on the request channel while
// req_ready is high. The word marked last is followed by the result
// computation steps (time code decode, the frame-rate multiply, and the
// final add with saturation), during which req_ready is low. The result
// sits in an output register; scanning of the next buffer goes on while it
// waits, and only the next buffer's final step waits for it to be taken.
// Configuration is written through a plain write port; the user must write
// it only while the block idles, and the block itself does not enforce this.
`default_nettype none

module mpeg2_gop_picture_duration_scanner #(
   parameter int PICTURE_COUNT_BITS = 24
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic                                 csr_index,
   input  wire logic [mgpds_pkg::START_W-1:0]        csr_write_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [7:0]                           req_data_byte,
   input  wire logic                                 req_last_byte,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [mgpds_pkg::DUR_W-1:0]        rsp_duration_frames,
   output logic [mgpds_pkg::GOPPIC_W-1:0]            rsp_first_gop_pictures,
   output logic                                      rsp_gop_found
);

   mgpds_pkg::dp_cmd_type cmd;

   // Sequencer.
   mgpds_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd)
   );

   // Datapath.
   mgpds_datapath #(
      .PICTURE_COUNT_BITS (PICTURE_COUNT_BITS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .req_data_byte          (req_data_byte),
      .rsp_duration_frames    (rsp_duration_frames),
      .rsp_first_gop_pictures (rsp_first_gop_pictures),
      .rsp_gop_found          (rsp_gop_found)
   );

endmodule

`default_nettype wire

[rtl/mgpds_ctrl.sv]
// ----------------------------------------------------------------------------
// mgpds_ctrl
// Sequencer: byte scanning, then the decode, multiply and finish steps of result computation.
// ----------------------------------------------------------------------------
`default_nettype none

module mgpds_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_last_byte,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output mgpds_pkg::dp_cmd_type       cmd
);

   mgpds_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;
   logic req_accept;

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mgpds_pkg::ST_SCAN: begin
            if (req_accept && req_last_byte) state_in = mgpds_pkg::ST_DECODE;
         end
         mgpds_pkg::ST_DECODE: state_in = mgpds_pkg::ST_MULT;
         mgpds_pkg::ST_MULT:   state_in = mgpds_pkg::ST_FINISH;
         mgpds_pkg::ST_FINISH: begin
            if (slot_free) state_in = mgpds_pkg::ST_SCAN;
         end
         default: state_in = mgpds_pkg::ST_SCAN;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         mgpds_pkg::ST_SCAN: begin
            req_ready   = 1'b1;
            cmd.scan_en = req_valid;
         end
         mgpds_pkg::ST_DECODE: cmd.decode_en = 1'b1;
         mgpds_pkg::ST_MULT:   cmd.mult_en   = 1'b1;
         mgpds_pkg::ST_FINISH: cmd.load_en   = slot_free;
         default: cmd = '0;
      endcase
   end

   // The result word is held until the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_en)    rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mgpds_pkg::ST_SCAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The last word starts the computation in the next cycle.
   a_last_starts_calc: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> state_ff == mgpds_pkg::ST_DECODE)
      else $error("last word did not start the result computation");

   // Decode is followed by the multiply and then the finish step.
   a_calc_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == mgpds_pkg::ST_DECODE |=> state_ff == mgpds_pkg::ST_MULT ##1
      state_ff == mgpds_pkg::ST_FINISH)
      else $error("result computation steps out of order");

   // A new result never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en |-> !rsp_valid_ff || rsp_ready)
      else $error("result word overwritten before delivery");

   // A loaded result is offered in the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en |=> rsp_valid_ff)
      else $error("loaded result not offered");

endmodule

`default_nettype wire

[rtl/mgpds_datapath.sv]
// ----------------------------------------------------------------------------
// mgpds_datapath
// Start code window, time code capture, picture counters, duration math.
// ----------------------------------------------------------------------------
`default_nettype none

module mgpds_datapath #(
   parameter int PICTURE_COUNT_BITS = 24
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire mgpds_pkg::dp_cmd_type                   cmd,
   input  wire logic                                    csr_write_enable,
   input  wire logic                                    csr_index,
   input  wire logic [mgpds_pkg::START_W-1:0]           csr_write_data,
   input  wire logic [7:0]                              req_data_byte,
   output logic signed [mgpds_pkg::DUR_W-1:0]           rsp_duration_frames,
   output logic [mgpds_pkg::GOPPIC_W-1:0]               rsp_first_gop_pictures,
   output logic                                         rsp_gop_found
);

   localparam int PCB   = PICTURE_COUNT_BITS;
   localparam int SUM_W = ((PCB > mgpds_pkg::PROD_W) ? PCB : mgpds_pkg::PROD_W) + 3;
   localparam logic signed [SUM_W-1:0] SUM_DUR_MAX = SUM_W'(mgpds_pkg::DUR_MAX);
   localparam logic signed [SUM_W-1:0] SUM_DUR_MIN = SUM_W'(mgpds_pkg::DUR_MIN);

   // Configuration registers.
   logic [mgpds_pkg::RATE_W-1:0]  frame_rate_ff;
   logic [mgpds_pkg::START_W-1:0] first_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rate_ff <= mgpds_pkg::FRAME_RATE_RESET;
         first_time_ff <= mgpds_pkg::FIRST_TIME_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mgpds_pkg::CSR_FRAME_RATE:
               frame_rate_ff <= csr_write_data[mgpds_pkg::RATE_W-1:0];
            mgpds_pkg::CSR_FIRST_TIME: first_time_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Scan state.
   logic [31:0]                    window_ff, window_in;
   logic [1:0]                     gop_count_ff, gop_count_in;
   logic [2:0]                     cap_left_ff, cap_left_in;
   logic [31:0]                    tc_ff, tc_in;
   logic [mgpds_pkg::GOPPIC_W-1:0] gop_pics_ff, gop_pics_in;
   logic [PCB-1:0]                 pics_ff, pics_in;

   // One stream word: shift the window, capture, then count start codes.
   always_comb begin
      window_in    = {window_ff[23:0], req_data_byte};
      gop_count_in = gop_count_ff;
      cap_left_in  = cap_left_ff;
      tc_in        = tc_ff;
      gop_pics_in  = gop_pics_ff;
      pics_in      = pics_ff;
      if (cap_left_ff != 3'd0) begin
         tc_in       = {tc_ff[23:0], req_data_byte};
         cap_left_in = cap_left_ff - 3'd1;
      end
      if (window_in == mgpds_pkg::GOP_CODE) begin
         if (gop_count_ff != 2'd2) gop_count_in = gop_count_ff + 2'd1;
         // Only the first GOP opens a time code capture.
         if (gop_count_ff == 2'd0) begin
            cap_left_in = 3'd4;
            tc_in       = '0;
         end
      end else if (window_in == mgpds_pkg::PIC_CODE && gop_count_ff != 2'd0) begin
         if (gop_count_ff == 2'd1 && gop_pics_ff != '1) gop_pics_in = gop_pics_ff + 1'b1;
         if (pics_ff != '1) pics_in = pics_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_en) begin
         window_ff    <= '1;
         gop_count_ff <= '0;
         cap_left_ff  <= '0;
         tc_ff        <= '0;
         gop_pics_ff  <= '0;
         pics_ff      <= '0;
      end else if (cmd.scan_en) begin
         window_ff    <= window_in;
         gop_count_ff <= gop_count_in;
         cap_left_ff  <= cap_left_in;
         tc_ff        <= tc_in;
         gop_pics_ff  <= gop_pics_in;
         pics_ff      <= pics_in;
      end
   end

   // Decode step: bytes still missing from the capture count as zero.
   logic [31:0]                   tc_full;
   logic [4:0]                    hh;
   logic [5:0]                    mm, ss;
   logic [mgpds_pkg::SECS_W-1:0]  secs_in, secs_ff;
   logic [mgpds_pkg::PP_W-1:0]    pp_in, pp_ff;

   always_comb begin
      unique case (cap_left_ff)
         3'd0:    tc_full = tc_ff;
         3'd1:    tc_full = {tc_ff[23:0], 8'd0};
         3'd2:    tc_full = {tc_ff[15:0], 16'd0};
         3'd3:    tc_full = {tc_ff[7:0], 24'd0};
         default: tc_full = '0;
      endcase
      hh      = tc_full[30:26];
      mm      = {tc_full[25:24], tc_full[23:20]};
      ss      = {tc_full[18:16], tc_full[15:13]};
      pp_in   = {tc_full[12:8], tc_full[7]};
      secs_in = mgpds_pkg::SECS_W'(hh * mgpds_pkg::SECS_PER_HOUR)
              + mgpds_pkg::SECS_W'(mm * mgpds_pkg::SECS_PER_MIN)
              + mgpds_pkg::SECS_W'(ss);
   end

   // Multiply step and its result register.
   logic [mgpds_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.decode_en) begin
         secs_ff <= secs_in;
         pp_ff   <= pp_in;
      end
      if (cmd.mult_en) prod_ff <= secs_ff * frame_rate_ff;
   end

   // Finish step: end time minus start time, saturated to the port range; zero when no GOP was found.
   logic signed [SUM_W-1:0]             dur_sum;
   logic signed [mgpds_pkg::DUR_W-1:0]  dur_sat;

   always_comb begin
      dur_sum = $signed({{(SUM_W-mgpds_pkg::PROD_W){1'b0}}, prod_ff})
              + $signed({{(SUM_W-mgpds_pkg::PP_W){1'b0}}, pp_ff})
              + $signed({{(SUM_W-PCB){1'b0}}, pics_ff})
              - $signed({{(SUM_W-mgpds_pkg::START_W){1'b0}}, first_time_ff});
      priority if (gop_count_ff == 2'd0) dur_sat = '0;
      else if (dur_sum > SUM_DUR_MAX)   dur_sat = mgpds_pkg::DUR_W'(mgpds_pkg::DUR_MAX);
      else if (dur_sum < SUM_DUR_MIN)   dur_sat = mgpds_pkg::DUR_W'(mgpds_pkg::DUR_MIN);
      else                              dur_sat = dur_sum[mgpds_pkg::DUR_W-1:0];
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         rsp_duration_frames    <= dur_sat;
         rsp_first_gop_pictures <= (gop_count_ff == 2'd0) ? '0 : gop_pics_ff;
         rsp_gop_found          <= (gop_count_ff != 2'd0);
      end
   end

endmodule

`default_nettype wire
